### sv/pdk_pkg.sv
package pdk_pkg;

  // field widths
  localparam int POS_W = 24;
  localparam int DIR_W = 16;
  localparam int LS_W  = 24;
  localparam int PW_W  = 16;
  localparam int KV_W  = 17;
  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PW = 1'b1;

  // register reset values
  localparam logic [LS_W-1:0] LS_RESET = 24'd65536;
  localparam logic [PW_W-1:0] PW_RESET = 16'd256;

  // log2(e) in Q.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // distance-over-length clamp, 32.0 in Q.16
  localparam logic [21:0] R_CAP = 22'h200000;

  // pipeline layout
  localparam int SQ_STEPS = 25;
  localparam int SQ_PER   = 2;
  localparam int SQ_ST    = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int DIV_STEPS = 22;
  localparam int DIV_PER   = 2;
  localparam int DIV_ST    = DIV_STEPS / DIV_PER;
  localparam int LOG_ST = 16;
  localparam int EXP_ST = 16;

  localparam int ST_SQR  = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_SQRT = 2;
  localparam int ST_DIV  = ST_SQRT + SQ_ST;
  localparam int ST_MUL  = ST_DIV + DIV_ST;
  localparam int ST_CMB  = ST_MUL + 1;
  localparam int ST_EXP  = ST_CMB + 1;
  localparam int ST_OUT  = ST_EXP + EXP_ST;
  localparam int NST     = ST_OUT + 1;

  localparam int ST_DOT  = 1;
  localparam int ST_LZ   = 2;
  localparam int ST_NORM = 3;
  localparam int ST_LOG  = 4;
  localparam int ST_G    = ST_LOG + LOG_ST;
  localparam int ST_DP   = ST_G + 1;
  localparam int DD_N    = ST_MUL - ST_DP + 1;
  localparam int NP_N    = ST_MUL - ST_DOT + 1;

  // |a - b| of two signed positions
  function automatic logic [POS_W:0] abs_diff(input logic [POS_W-1:0] a,
                                              input logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? (~d + 1'b1) : d;
  endfunction

  // floor square root, elaboration only
  function automatic longint unsigned isqrt_const(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned w;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    w = v;
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (w >= r + b) begin
          w = w - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(-2^-idx) in Q.30, idx from 1
  function automatic logic [29:0] exp_tab(input int idx);
    longint unsigned t;
    t = isqrt_const(64'd1 << 59);
    for (int j = 1; j < 16; j++) begin
      if (j < idx) t = isqrt_const(t << 30);
    end
    return t[29:0];
  endfunction

  localparam logic [29:0] EXP_TAB [EXP_ST] = '{
    exp_tab(1),  exp_tab(2),  exp_tab(3),  exp_tab(4),
    exp_tab(5),  exp_tab(6),  exp_tab(7),  exp_tab(8),
    exp_tab(9),  exp_tab(10), exp_tab(11), exp_tab(12),
    exp_tab(13), exp_tab(14), exp_tab(15), exp_tab(16)
  };

endpackage

### sv/position_direction_kernel.sv
// Covariance of one pair of oriented points: exp(-|p_train - p_query| / length_scale)
// times max(d_train . d_query, 0) raised to direction_power, as unsigned Q0.16 saturated
// to one. Positions are Q8.16, directions Q1.14, the length scale Q8.16 and the power
// Q8.8. The block is a 45-stage pipeline that takes one request every cycle while the
// output is not stalled; the depth is set by the digit-serial square root (two root bits
// per stage), the restoring divider (two quotient bits per stage) and the sixteen
// multiply stages of the power-of-two unit, while the sixteen squaring stages of the
// log unit run alongside. Every stage stalls only when the stages after it are full, so
// bubbles close up while a result waits at the output. The user must write the registers
// only while no request is in flight; the block itself does not enforce this.
module position_direction_kernel
  import pdk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_train_px,
  input  logic signed [POS_W-1:0] in_train_py,
  input  logic signed [POS_W-1:0] in_train_pz,
  input  logic signed [DIR_W-1:0] in_train_dx,
  input  logic signed [DIR_W-1:0] in_train_dy,
  input  logic signed [DIR_W-1:0] in_train_dz,
  input  logic signed [POS_W-1:0] in_query_px,
  input  logic signed [POS_W-1:0] in_query_py,
  input  logic signed [POS_W-1:0] in_query_pz,
  input  logic signed [DIR_W-1:0] in_query_dx,
  input  logic signed [DIR_W-1:0] in_query_dy,
  input  logic signed [DIR_W-1:0] in_query_dz,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KV_W-1:0]         out_kernel_value,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  // configuration registers
  logic [LS_W-1:0] ls_r;
  logic [PW_W-1:0] pw_r;
  logic [LS_W-1:0] ls_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r <= LS_RESET;
      pw_r <= PW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_LS: ls_r <= cfg_data[LS_W-1:0];
        CFG_IDX_PW: pw_r <= cfg_data[PW_W-1:0];
      endcase
    end
  end

  // zero length scale acts as one lsb
  assign ls_eff = (ls_r == '0) ? LS_W'(1) : ls_r;

  // stage valids and per-stage enables
  logic [NST-1:0] vld_r;
  logic [NST-1:0] st_en;
  logic [NST-1:0] vld_in;

  for (genvar s = 0; s < NST; s++) begin : g_en
    assign st_en[s] = out_ready | ~(&vld_r[NST-1:s]);
  end

  assign vld_in   = {vld_r[NST-2:0], in_valid};
  assign in_ready = st_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (st_en[s]) vld_r[s] <= vld_in[s];
      end
    end
  end

  // ---------------- position path ----------------

  // squared differences
  logic [POS_W:0]   ad_x, ad_y, ad_z;
  logic [48:0]      sq_r [3];
  logic [49:0]      sum_r;

  assign ad_x = abs_diff(in_train_px, in_query_px);
  assign ad_y = abs_diff(in_train_py, in_query_py);
  assign ad_z = abs_diff(in_train_pz, in_query_pz);

  always_ff @(posedge clk) begin
    if (st_en[ST_SQR]) begin
      sq_r[0] <= 49'(ad_x) * 49'(ad_x);
      sq_r[1] <= 49'(ad_y) * 49'(ad_y);
      sq_r[2] <= 49'(ad_z) * 49'(ad_z);
    end
    if (st_en[ST_SUM]) begin
      sum_r <= 50'(sq_r[0]) + 50'(sq_r[1]) + 50'(sq_r[2]);
    end
  end

  // digit-serial square root, two root bits per stage
  logic [25:0] sq_rem_r   [SQ_ST];
  logic [24:0] sq_root_r  [SQ_ST];
  logic [49:0] sq_v_r     [SQ_ST];
  logic [25:0] sq_rem_nxt [SQ_ST];
  logic [24:0] sq_root_nxt[SQ_ST];
  logic [49:0] sq_v_nxt   [SQ_ST];

  always_comb begin
    logic [25:0] rem;
    logic [24:0] root;
    logic [49:0] v;
    logic [27:0] rem_sh;
    logic [27:0] trial;
    for (int s = 0; s < SQ_ST; s++) begin
      if (s == 0) begin
        rem  = '0;
        root = '0;
        v    = sum_r;
      end else begin
        rem  = sq_rem_r[s-1];
        root = sq_root_r[s-1];
        v    = sq_v_r[s-1];
      end
      for (int j = 0; j < SQ_PER; j++) begin
        if (s * SQ_PER + j < SQ_STEPS) begin
          rem_sh = {rem, v[49:48]};
          trial  = {1'b0, root, 2'b01};
          if (rem_sh >= trial) begin
            rem_sh = rem_sh - trial;
            root   = {root[23:0], 1'b1};
          end else begin
            root   = {root[23:0], 1'b0};
          end
          rem = rem_sh[25:0];
          v   = {v[47:0], 2'b00};
        end
      end
      sq_rem_nxt[s]  = rem;
      sq_root_nxt[s] = root;
      sq_v_nxt[s]    = v;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SQ_ST; s++) begin
      if (st_en[ST_SQRT+s]) begin
        sq_rem_r[s]  <= sq_rem_nxt[s];
        sq_root_r[s] <= sq_root_nxt[s];
        sq_v_r[s]    <= sq_v_nxt[s];
      end
    end
  end

  // restoring divide of the distance << 16 by the length scale
  logic [LS_W-1:0] dv_rem_r   [DIV_ST];
  logic [21:0]     dv_q_r     [DIV_ST];
  logic [21:0]     dv_n_r     [DIV_ST];
  logic            dv_ovf_r   [DIV_ST];
  logic [LS_W-1:0] dv_rem_nxt [DIV_ST];
  logic [21:0]     dv_q_nxt   [DIV_ST];
  logic [21:0]     dv_n_nxt   [DIV_ST];
  logic            dv_ovf_nxt [DIV_ST];
  logic [24:0]     pos_dist;

  assign pos_dist = sq_root_r[SQ_ST-1];

  always_comb begin
    logic [LS_W-1:0] rem;
    logic [21:0]     q;
    logic [21:0]     n;
    logic            ovf;
    logic [LS_W:0]   rem_sh;
    for (int s = 0; s < DIV_ST; s++) begin
      if (s == 0) begin
        rem = LS_W'(pos_dist[24:6]);
        q   = '0;
        n   = {pos_dist[5:0], 16'h0000};
        ovf = (LS_W'(pos_dist[24:6]) >= ls_eff);
      end else begin
        rem = dv_rem_r[s-1];
        q   = dv_q_r[s-1];
        n   = dv_n_r[s-1];
        ovf = dv_ovf_r[s-1];
      end
      for (int j = 0; j < DIV_PER; j++) begin
        rem_sh = {rem, n[21]};
        n      = {n[20:0], 1'b0};
        if (rem_sh >= {1'b0, ls_eff}) begin
          rem_sh = rem_sh - {1'b0, ls_eff};
          q      = {q[20:0], 1'b1};
        end else begin
          q      = {q[20:0], 1'b0};
        end
        rem = rem_sh[LS_W-1:0];
      end
      dv_rem_nxt[s] = rem;
      dv_q_nxt[s]   = q;
      dv_n_nxt[s]   = n;
      dv_ovf_nxt[s] = ovf;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_ST; s++) begin
      if (st_en[ST_DIV+s]) begin
        dv_rem_r[s] <= dv_rem_nxt[s];
        dv_q_r[s]   <= dv_q_nxt[s];
        dv_n_r[s]   <= dv_n_nxt[s];
        dv_ovf_r[s] <= dv_ovf_nxt[s];
      end
    end
  end

  // clamp and scale by log2(e)
  logic [21:0] r_clamp;
  logic [52:0] mp_r;

  assign r_clamp = (dv_ovf_r[DIV_ST-1] || dv_q_r[DIV_ST-1] > R_CAP) ? R_CAP
                                                                    : dv_q_r[DIV_ST-1];

  always_ff @(posedge clk) begin
    if (st_en[ST_MUL]) mp_r <= 53'(r_clamp) * 53'(LOG2E_Q30);
  end

  // ---------------- direction path ----------------

  // dot product
  logic signed [31:0] dp_r [3];
  logic signed [33:0] dot;
  logic [28:0]        c_r;
  logic [28:0]        c2_r;
  logic               npos_r [NP_N];
  logic [4:0]         lz_m_r;
  logic [4:0]         lz_m;
  logic [30:0]        nm_x_r;
  logic [4:0]         nm_m_r;

  assign dot = 34'(dp_r[0]) + 34'(dp_r[1]) + 34'(dp_r[2]);

  // top set bit of the cosine
  always_comb begin
    lz_m = '0;
    for (int b = 0; b < 29; b++) begin
      if (c_r[b]) lz_m = 5'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (st_en[ST_SQR]) begin
      dp_r[0] <= 32'(in_train_dx) * 32'(in_query_dx);
      dp_r[1] <= 32'(in_train_dy) * 32'(in_query_dy);
      dp_r[2] <= 32'(in_train_dz) * 32'(in_query_dz);
    end
    if (st_en[ST_DOT]) begin
      npos_r[0] <= (dot <= 34'sd0);
      if (dot <= 34'sd0)             c_r <= '0;
      else if (dot > 34'sd268435456) c_r <= 29'h1000_0000;
      else                           c_r <= dot[28:0];
    end
    if (st_en[ST_LZ]) begin
      c2_r   <= c_r;
      lz_m_r <= lz_m;
    end
    if (st_en[ST_NORM]) begin
      nm_x_r <= 31'(c2_r) << (5'd30 - lz_m_r);
      nm_m_r <= lz_m_r;
    end
    for (int k = 1; k < NP_N; k++) begin
      if (st_en[ST_DOT+k]) npos_r[k] <= npos_r[k-1];
    end
  end

  // log2 fraction by repeated squaring, one bit per stage
  logic [30:0] lg_x_r   [LOG_ST];
  logic [15:0] lg_f_r   [LOG_ST];
  logic [4:0]  lg_m_r   [LOG_ST];
  logic [30:0] lg_x_nxt [LOG_ST];
  logic [15:0] lg_f_nxt [LOG_ST];

  always_comb begin
    logic [30:0] x;
    logic [15:0] f;
    logic [61:0] sqr;
    for (int s = 0; s < LOG_ST; s++) begin
      if (s == 0) begin
        x = nm_x_r;
        f = '0;
      end else begin
        x = lg_x_r[s-1];
        f = lg_f_r[s-1];
      end
      sqr = 62'(x) * 62'(x);
      if (sqr[61]) begin
        x = sqr[61:31];
        f = {f[14:0], 1'b1};
      end else begin
        x = sqr[60:30];
        f = {f[14:0], 1'b0};
      end
      lg_x_nxt[s] = x;
      lg_f_nxt[s] = f;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < LOG_ST; s++) begin
      if (st_en[ST_LOG+s]) begin
        lg_x_r[s] <= lg_x_nxt[s];
        lg_f_r[s] <= lg_f_nxt[s];
        lg_m_r[s] <= (s == 0) ? nm_m_r : lg_m_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  // -log2(cosine) and the power, then aligned with the position path
  logic [20:0] g_r;
  logic [36:0] dpow;
  logic [28:0] dd_r [DD_N];

  assign dpow = 37'(pw_r) * 37'(g_r);

  always_ff @(posedge clk) begin
    if (st_en[ST_G]) begin
      g_r <= {5'd28 - lg_m_r[LOG_ST-1], 16'h0000} - {5'd0, lg_f_r[LOG_ST-1]};
    end
    if (st_en[ST_DP]) begin
      dd_r[0] <= npos_r[ST_G-ST_DOT] ? '0 : dpow[36:8];
    end
    for (int k = 1; k < DD_N; k++) begin
      if (st_en[ST_DP+k]) dd_r[k] <= dd_r[k-1];
    end
  end

  // ---------------- combine and power of two ----------------

  logic [52:0] p_rnd;
  logic [29:0] e_sum;
  logic [15:0] cb_f_r;
  logic [4:0]  cb_k_r;
  logic        cb_kill_r;

  assign p_rnd = mp_r + (53'd1 << 29);
  assign e_sum = 30'(p_rnd[52:30]) + 30'(dd_r[DD_N-1]);

  always_ff @(posedge clk) begin
    if (st_en[ST_CMB]) begin
      cb_f_r    <= e_sum[15:0];
      cb_k_r    <= e_sum[20:16];
      cb_kill_r <= (npos_r[NP_N-1] && pw_r != '0) || (e_sum[29:16] > 14'd17);
    end
  end

  // fractional power of two, one table factor per stage
  logic [30:0] ex_y_r    [EXP_ST];
  logic [15:0] ex_f_r    [EXP_ST];
  logic [4:0]  ex_k_r    [EXP_ST];
  logic        ex_kill_r [EXP_ST];
  logic [30:0] ex_y_nxt  [EXP_ST];

  always_comb begin
    logic [30:0] y;
    logic [15:0] f;
    logic [60:0] yp;
    for (int s = 0; s < EXP_ST; s++) begin
      if (s == 0) begin
        y = 31'h4000_0000;
        f = cb_f_r;
      end else begin
        y = ex_y_r[s-1];
        f = ex_f_r[s-1];
      end
      yp = 61'(y) * 61'(EXP_TAB[s]);
      ex_y_nxt[s] = f[15-s] ? yp[60:30] : y;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < EXP_ST; s++) begin
      if (st_en[ST_EXP+s]) begin
        ex_y_r[s] <= ex_y_nxt[s];
        if (s == 0) begin
          ex_f_r[s]    <= cb_f_r;
          ex_k_r[s]    <= cb_k_r;
          ex_kill_r[s] <= cb_kill_r;
        end else begin
          ex_f_r[s]    <= ex_f_r[(s == 0) ? 0 : s-1];
          ex_k_r[s]    <= ex_k_r[(s == 0) ? 0 : s-1];
          ex_kill_r[s] <= ex_kill_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  // round to Q0.16 with the integer shift
  logic [31:0]     y_rnd;
  logic [KV_W-1:0] kv_r;

  assign y_rnd = 32'(ex_y_r[EXP_ST-1]) + (32'd1 << (5'd13 + ex_k_r[EXP_ST-1]));

  always_ff @(posedge clk) begin
    if (st_en[ST_OUT]) begin
      kv_r <= ex_kill_r[EXP_ST-1] ? '0
                                  : KV_W'(y_rnd >> (5'd14 + ex_k_r[EXP_ST-1]));
    end
  end

  assign out_valid        = vld_r[NST-1];
  assign out_kernel_value = kv_r;

  // checks
  a_kv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kernel_value <= 17'd65536)
    else $error("kernel value above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_NORM] && !npos_r[ST_NORM-ST_DOT]) |-> nm_x_r[30])
    else $error("cosine not normalized");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !vld_r[NST-2]) |=> !out_valid)
    else $error("result repeated after delivery");

endmodule
